// ----- rtl/core/quad_batch_texture_slot_binder_defines.svh -----
// Assertion macros shared by the quad batch texture slot binder RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef QUAD_BATCH_TEXTURE_SLOT_BINDER_DEFINES_SVH
`define QUAD_BATCH_TEXTURE_SLOT_BINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QBTSB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QBTSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/qbtsb_pkg.sv -----
// Shared types, codes and default sizes for the quad batch texture slot binder.
// No dependencies; imported by the slot cell, the top level, the checker and the testbench.
package qbtsb_pkg;

  // Default sizes of the batch and the slot table.
  localparam int MAX_QUADS_DEF     = 8192;
  localparam int TEXTURE_SLOTS_DEF = 16;
  localparam int ID_WIDTH_DEF      = 16;

  // Port field widths.
  localparam int OP_W          = 2;
  localparam int IN_DATA_W     = 16;
  localparam int KIND_W        = 2;
  localparam int SLOT_FIELD_W  = 4;
  localparam int QUADS_FIELD_W = 14;
  localparam int TEX_FIELD_W   = 5;
  localparam int OUT_DATA_W    = 24;
  localparam int OUT_PAD_W     = OUT_DATA_W - SLOT_FIELD_W - QUADS_FIELD_W - TEX_FIELD_W;

  typedef enum logic [OP_W-1:0] {
    OP_BEGIN    = 2'd0,
    OP_PLAIN    = 2'd1,
    OP_TEXTURED = 2'd2,
    OP_END      = 2'd3
  } op_t;

  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_EXEC   = 4'b0100,
    S_SECOND = 4'b1000
  } state_t;

  // Control part of a lookup traveling down the slot chain.
  typedef struct packed {
    logic valid;
    logic found;
  } pkt_ctl_t;

endpackage

// ----- rtl/core/quad_batch_texture_slot_binder.sv -----
// Quad batch texture slot binder: takes begin frame, plain quad, textured quad and
// end frame requests, binds texture ids to a slot table and reports accepted quads,
// flushed batches and dropped quads. Slot 0 is the fixed white texture. A textured
// quad's id walks a chain of TEXTURE_SLOTS-1 slot cells, one cell per cycle, before its
// result is formed; no new request is accepted until the current one is done and its
// result has gone into the output register. A textured quad that finds the table full
// behind a non-empty batch yields a flush item and then an accept item. Results leave
// through an output register, so the next request is accepted while a result still
// waits to be taken.
// Depends on qbtsb_pkg, qbtsb_cell and quad_batch_texture_slot_binder_defines.svh.
`include "quad_batch_texture_slot_binder_defines.svh"

module quad_batch_texture_slot_binder #(
  parameter int MAX_QUADS     = qbtsb_pkg::MAX_QUADS_DEF,
  parameter int TEXTURE_SLOTS = qbtsb_pkg::TEXTURE_SLOTS_DEF,
  parameter int ID_WIDTH      = qbtsb_pkg::ID_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request channel.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [qbtsb_pkg::IN_DATA_W-1:0]  in_tdata,   // [15:0] texture_id
  input  logic [qbtsb_pkg::OP_W-1:0]       in_tuser,   // [1:0] op
  // Result channel.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [qbtsb_pkg::OUT_DATA_W-1:0] out_tdata,  // [3:0] slot, [17:4] batch_quads,
                                                       // [22:18] batch_textures, [23] zero
  output logic [qbtsb_pkg::KIND_W-1:0]     out_tuser,  // [1:0] kind
  output logic                             out_tlast   // last result of this request
);
  import qbtsb_pkg::*;

  localparam int CELLS    = TEXTURE_SLOTS - 1;
  localparam int SLOT_W   = $clog2(TEXTURE_SLOTS);
  localparam int CNT_W    = $clog2(TEXTURE_SLOTS + 1);
  localparam int QCNT_W   = $clog2(MAX_QUADS + 1);
  localparam int ID_EXT_W = IN_DATA_W + ID_WIDTH;

  // Control and latched request.
  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic                found_r, found_nxt;
  logic [SLOT_W-1:0]   slot_hit_r, slot_hit_nxt;

  // Batch state.
  logic [CNT_W-1:0]    slot_count_r, slot_count_nxt;
  logic [QCNT_W-1:0]   quad_count_r, quad_count_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]   out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [QCNT_W-1:0]   out_quads_r, out_quads_nxt;
  logic [CNT_W-1:0]    out_texs_r, out_texs_nxt;
  logic                out_last_r, out_last_nxt;

  // Result produced this cycle.
  logic                load_en;
  logic [KIND_W-1:0]   load_kind;
  logic [SLOT_W-1:0]   load_slot;
  logic [QCNT_W-1:0]   load_quads;
  logic [CNT_W-1:0]    load_texs;
  logic                load_last;

  // Slot table write port.
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;

  logic                in_accept;
  logic                out_space;
  logic                at_limit;
  op_t                 in_op;
  logic [ID_EXT_W-1:0] id_ext;
  logic [ID_WIDTH-1:0] id_in;

  // Links between neighboring slot cells; link 0 feeds the first cell.
  pkt_ctl_t            ctl_link  [CELLS+1];
  logic [ID_WIDTH-1:0] id_link   [CELLS+1];
  logic [SLOT_W-1:0]   slot_link [CELLS+1];

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign in_op     = op_t'(in_tuser);
  // The id is the low ID_WIDTH bits of the data field, zero-extended if wider.
  assign id_ext    = ID_EXT_W'(in_tdata);
  assign id_in     = id_ext[ID_WIDTH-1:0];
  assign out_space = !out_valid_r || out_tready;
  assign at_limit  = quad_count_r >= QCNT_W'(MAX_QUADS);

  // A textured quad starts its lookup in the cycle it is accepted.
  assign ctl_link[0].valid = in_accept && (in_op == OP_TEXTURED);
  assign ctl_link[0].found = 1'b0;
  assign id_link[0]        = id_in;
  assign slot_link[0]      = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    qbtsb_cell #(
      .ID_WIDTH (ID_WIDTH),
      .SLOT_W   (SLOT_W),
      .CNT_W    (CNT_W),
      .INDEX    (k + 1)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl_i      (ctl_link[k]),
      .id_i       (id_link[k]),
      .slot_i     (slot_link[k]),
      .ctl_o      (ctl_link[k+1]),
      .id_o       (id_link[k+1]),
      .slot_o     (slot_link[k+1]),
      .slot_count (slot_count_r),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_id      (id_r)
    );
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    found_nxt      = found_r;
    slot_hit_nxt   = slot_hit_r;
    slot_count_nxt = slot_count_r;
    quad_count_nxt = quad_count_r;
    wr_en          = 1'b0;
    wr_addr        = SLOT_W'(slot_count_r);
    load_en        = 1'b0;
    load_kind      = KIND_ACCEPT;
    load_slot      = '0;
    load_quads     = '0;
    load_texs      = '0;
    load_last      = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          op_nxt    = in_op;
          id_nxt    = id_in;
          state_nxt = (in_op == OP_TEXTURED) ? S_SEARCH : S_EXEC;
        end
      end
      S_SEARCH: begin
        // The lookup leaves the last cell with its verdict.
        if (ctl_link[CELLS].valid) begin
          found_nxt    = ctl_link[CELLS].found;
          slot_hit_nxt = slot_link[CELLS];
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_space) begin
          state_nxt = S_IDLE;
          case (op_r)
            OP_BEGIN: begin
              quad_count_nxt = '0;
              slot_count_nxt = CNT_W'(1);
            end
            OP_END: begin
              // End of frame reports the batch but keeps it.
              if (quad_count_r != '0) begin
                load_en    = 1'b1;
                load_kind  = KIND_FLUSH;
                load_quads = quad_count_r;
                load_texs  = slot_count_r;
              end
            end
            default: begin
              if (at_limit) begin
                load_en   = 1'b1;
                load_kind = KIND_DROP;
              end else if (op_r == OP_PLAIN) begin
                quad_count_nxt = quad_count_r + QCNT_W'(1);
                load_en        = 1'b1;
              end else if (found_r) begin
                quad_count_nxt = quad_count_r + QCNT_W'(1);
                load_en        = 1'b1;
                load_slot      = slot_hit_r;
              end else if (slot_count_r < CNT_W'(TEXTURE_SLOTS)) begin
                // Append the id behind the slots in use.
                wr_en          = 1'b1;
                slot_count_nxt = slot_count_r + CNT_W'(1);
                quad_count_nxt = quad_count_r + QCNT_W'(1);
                load_en        = 1'b1;
                load_slot      = SLOT_W'(slot_count_r);
              end else begin
                // Table full: start a new batch with this id in slot 1.
                wr_en          = 1'b1;
                wr_addr        = SLOT_W'(1);
                slot_count_nxt = CNT_W'(2);
                quad_count_nxt = QCNT_W'(1);
                load_en        = 1'b1;
                if (quad_count_r != '0) begin
                  load_kind  = KIND_FLUSH;
                  load_quads = quad_count_r;
                  load_texs  = slot_count_r;
                  load_last  = 1'b0;
                  state_nxt  = S_SECOND;
                end else begin
                  load_slot = SLOT_W'(1);
                end
              end
            end
          endcase
        end
      end
      S_SECOND: begin
        // The quad that forced the flush is accepted into slot 1.
        if (out_space) begin
          load_en   = 1'b1;
          load_slot = SLOT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_quads_nxt = out_quads_r;
    out_texs_nxt  = out_texs_r;
    out_last_nxt  = out_last_r;
    if (load_en) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = load_kind;
      out_slot_nxt  = load_slot;
      out_quads_nxt = load_quads;
      out_texs_nxt  = load_texs;
      out_last_nxt  = load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_count_r <= CNT_W'(1);
      quad_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_count_r <= slot_count_nxt;
      quad_count_r <= quad_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    found_r     <= found_nxt;
    slot_hit_r  <= slot_hit_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_quads_r <= out_quads_nxt;
    out_texs_r  <= out_texs_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}},
                       TEX_FIELD_W'(out_texs_r),
                       QUADS_FIELD_W'(out_quads_r),
                       SLOT_FIELD_W'(out_slot_r)};

  // The fill level always counts the white slot and never passes the table size.
  `QBTSB_ASSERT_NOW(a_slot_count_range, 1'b1,
    (slot_count_r != '0) && (slot_count_r <= CNT_W'(TEXTURE_SLOTS)),
    "slot count out of range")
  // The batch never holds more quads than the limit.
  `QBTSB_ASSERT_NOW(a_quad_count_range, 1'b1,
    quad_count_r <= QCNT_W'(MAX_QUADS), "quad count above limit")
  // A lookup only leaves the chain while the controller waits for it.
  `QBTSB_ASSERT_NOW(a_chain_tail_in_search, ctl_link[CELLS].valid,
    state_r == S_SEARCH, "lookup left the chain outside the search state")
  // While the second result is pending, the flush item still sits in the output.
  `QBTSB_ASSERT_NOW(a_second_behind_flush, state_r == S_SECOND,
    out_valid_r && (out_kind_r == KIND_FLUSH) && !out_last_r,
    "second result pending without a held flush")

endmodule

// ----- rtl/core/qbtsb_cell.sv -----
// One slot of the texture table: holds a texture id and checks a passing lookup.
// Depends on qbtsb_pkg for the lookup control struct.
module qbtsb_cell #(
  parameter int ID_WIDTH = qbtsb_pkg::ID_WIDTH_DEF,
  parameter int SLOT_W   = 4,
  parameter int CNT_W    = 5,
  parameter int INDEX    = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qbtsb_pkg::pkt_ctl_t  ctl_i,
  input  logic [ID_WIDTH-1:0]  id_i,
  input  logic [SLOT_W-1:0]    slot_i,
  output qbtsb_pkg::pkt_ctl_t  ctl_o,
  output logic [ID_WIDTH-1:0]  id_o,
  output logic [SLOT_W-1:0]    slot_o,
  input  logic [CNT_W-1:0]     slot_count,
  input  logic                 wr_en,
  input  logic [SLOT_W-1:0]    wr_addr,
  input  logic [ID_WIDTH-1:0]  wr_id
);
  import qbtsb_pkg::*;

  logic [ID_WIDTH-1:0] stored_id_r;
  pkt_ctl_t            ctl_r;
  pkt_ctl_t            ctl_nxt;
  logic [ID_WIDTH-1:0] id_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   slot_nxt;
  logic                in_use;
  logic                hit;

  // Only slots below the fill level hold written ids.
  assign in_use = CNT_W'(INDEX) < slot_count;
  assign hit    = ctl_i.valid && !ctl_i.found && in_use && (stored_id_r == id_i);

  always_comb begin
    ctl_nxt.valid = ctl_i.valid;
    ctl_nxt.found = ctl_i.found | hit;
    slot_nxt      = hit ? SLOT_W'(INDEX) : slot_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_i;
    slot_r <= slot_nxt;
    if (wr_en && (wr_addr == SLOT_W'(INDEX))) begin
      stored_id_r <= wr_id;
    end
  end

  assign ctl_o  = ctl_r;
  assign id_o   = id_r;
  assign slot_o = slot_r;

endmodule

// ----- dv/qbtsb_bind_checker.sv -----
// Checker for the quad batch texture slot binder: watches both streams, keeps its own
// copy of the slot table and batch counters, and compares every result in order.
// Depends on qbtsb_pkg for the op codes, result kinds and port field widths.
module qbtsb_bind_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [qbtsb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [qbtsb_pkg::OP_W-1:0]       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [qbtsb_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [qbtsb_pkg::KIND_W-1:0]     out_tuser,
  input  logic                             out_tlast,
  input  logic                             run_done,
  output int                               fail_count,
  output int                               pending,
  output int                               results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import qbtsb_pkg::*;

  localparam int QUADS_LSB = SLOT_FIELD_W;
  localparam int TEX_LSB   = SLOT_FIELD_W + QUADS_FIELD_W;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic [QUADS_FIELD_W-1:0] quads;
    logic [TEX_FIELD_W-1:0]   texs;
    logic                     last;
  } bind_result_t;

  logic [ID_WIDTH_DEF-1:0]  slot_tab [1:TEXTURE_SLOTS_DEF-1];
  logic [TEX_FIELD_W-1:0]   slots_used;
  logic [QUADS_FIELD_W-1:0] quads_in_batch;
  bind_result_t             owed_results [$];
  bit                       leftovers_checked;

  task automatic report(input string what);
    if (fail_count < 100) begin
      $display("%0t ns: result %0d: %s", $realtime, results_checked, what);
    end
    fail_count++;
  endtask

  task automatic owe(input logic [KIND_W-1:0] kind, input logic [SLOT_FIELD_W-1:0] slot,
                     input logic [QUADS_FIELD_W-1:0] quads,
                     input logic [TEX_FIELD_W-1:0] texs, input logic last);
    bind_result_t r;
    r.kind  = kind;
    r.slot  = slot;
    r.quads = quads;
    r.texs  = texs;
    r.last  = last;
    owed_results.push_back(r);
  endtask

  // Applies one request to the local slot table and queues the results it causes.
  task automatic bind_request(input op_t op, input logic [IN_DATA_W-1:0] tex_id);
    logic [ID_WIDTH_DEF-1:0] id;
    logic [SLOT_FIELD_W-1:0] slot;
    bit                      hit;
    int                      i;
    id   = tex_id[ID_WIDTH_DEF-1:0];
    slot = '0;
    hit  = 1'b0;
    case (op)
      OP_BEGIN: begin
        quads_in_batch = '0;
        slots_used     = TEX_FIELD_W'(1);
      end
      OP_END: begin
        if (quads_in_batch != 0) owe(KIND_FLUSH, '0, quads_in_batch, slots_used, 1'b1);
      end
      default: begin
        if (quads_in_batch >= MAX_QUADS_DEF) begin
          owe(KIND_DROP, '0, '0, '0, 1'b1);
        end else begin
          if (op == OP_TEXTURED) begin
            for (i = 1; i < TEXTURE_SLOTS_DEF; i++) begin
              if (!hit && i < slots_used && slot_tab[i] == id) begin
                slot = SLOT_FIELD_W'(i);
                hit  = 1'b1;
              end
            end
            if (!hit) begin
              // A full table forces a flush; an empty batch flushes silently.
              if (slots_used >= TEXTURE_SLOTS_DEF) begin
                if (quads_in_batch != 0) owe(KIND_FLUSH, '0, quads_in_batch, slots_used, 1'b0);
                quads_in_batch = '0;
                slots_used     = TEX_FIELD_W'(1);
              end
              slot                 = slots_used[SLOT_FIELD_W-1:0];
              slot_tab[slots_used] = id;
              slots_used++;
            end
          end
          quads_in_batch++;
          owe(KIND_ACCEPT, slot, '0, '0, 1'b1);
        end
      end
    endcase
  endtask

  task automatic check_result();
    bind_result_t want;
    if (owed_results.size() == 0) begin
      report($sformatf("result with nothing owed: kind %0d data 0x%06h last %0b",
                       out_tuser, out_tdata, out_tlast));
    end else begin
      want = owed_results.pop_front();
      results_checked++;
      if (out_tuser !== want.kind)
        report($sformatf("kind %0d, want %0d", out_tuser, want.kind));
      if (out_tdata[SLOT_FIELD_W-1:0] !== want.slot)
        report($sformatf("slot %0d, want %0d", out_tdata[SLOT_FIELD_W-1:0], want.slot));
      if (out_tdata[QUADS_LSB +: QUADS_FIELD_W] !== want.quads)
        report($sformatf("batch_quads %0d, want %0d",
                         out_tdata[QUADS_LSB +: QUADS_FIELD_W], want.quads));
      if (out_tdata[TEX_LSB +: TEX_FIELD_W] !== want.texs)
        report($sformatf("batch_textures %0d, want %0d",
                         out_tdata[TEX_LSB +: TEX_FIELD_W], want.texs));
      if (out_tdata[OUT_DATA_W-1 -: OUT_PAD_W] !== '0)
        report($sformatf("pad bits 0x%0h, want zero", out_tdata[OUT_DATA_W-1 -: OUT_PAD_W]));
      if (out_tlast !== want.last)
        report($sformatf("last %0b, want %0b", out_tlast, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      owed_results.delete();
      slots_used        = TEX_FIELD_W'(1);
      quads_in_batch    = '0;
      leftovers_checked = 1'b0;
      fail_count        = 0;
      results_checked   = 0;
      pending <= 0;
    end else begin
      if (in_tvalid && in_tready) bind_request(op_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) check_result();
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (owed_results.size() != 0)
          report($sformatf("%0d results never arrived", owed_results.size()));
      end
      pending <= owed_results.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the quad batch texture slot binder: clock, reset, request stimulus,
// result back-pressure and the verdict. Depends on qbtsb_pkg, the block's RTL and
// qbtsb_bind_checker, which does all prediction and comparison.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qbtsb_pkg::*;

  // The slowest request walks the whole slot chain; the drain at the end waits well
  // beyond that after the last owed result has arrived.
  localparam int SETTLE_CYCLES  = 4 * (TEXTURE_SLOTS_DEF + 2);
  // Random requests after the directed part, which sends 25, for about 1100 in all.
  localparam int RANDOM_ITEMS   = 1075;

  // Receiver behavior, picked anew for each stretch of cycles.
  localparam int READY_ALWAYS = 0;
  localparam int READY_COIN   = 1;
  localparam int READY_SPARSE = 2;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]     out_tuser;
  logic                  out_tlast;
  logic                  run_done = 1'b0;

  int fail_count;
  int pending;
  int results_checked;
  int items_sent;
  int burst_left;
  int stall_mode, stall_left, stall_period, stall_tick;

  always #2 clk = ~clk;

  quad_batch_texture_slot_binder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  qbtsb_bind_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .run_done        (run_done),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  // Result back-pressure. Each stretch is either always ready, a coin toss per cycle,
  // or ready only one cycle in a random period, so stalls of many lengths hit both
  // single results and the flush-then-accept pair.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode   = $urandom_range(READY_ALWAYS, READY_SPARSE);
      stall_left   = $urandom_range(16, 96);
      stall_period = $urandom_range(2, 24);
      stall_tick   = 0;
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      READY_ALWAYS: out_tready <= 1'b1;
      READY_COIN:   out_tready <= 1'($urandom_range(0, 1));
      default:      out_tready <= (stall_tick % stall_period) == 0;
    endcase
  end

  // Sends one request. The sender works in bursts; between bursts valid may drop for a
  // random gap while the data lines carry junk. Valid is left high after acceptance
  // so that a following burst item goes out back to back.
  task automatic send_request(input op_t op, input logic [IN_DATA_W-1:0] tex_id);
    int gap;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(32, 96) : $urandom_range(1, 8);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        in_tdata  <= IN_DATA_W'($urandom_range(0, 16'hFFFF));
        in_tuser  <= OP_W'($urandom_range(0, 3));
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= tex_id;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  // Holds the sender off until every owed result has been taken. The first edge lets
  // the checker count the item that was accepted last.
  task automatic drain_results();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [IN_DATA_W-1:0] random_id();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return IN_DATA_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  initial begin
    logic [IN_DATA_W-1:0] tex_pool [0:23];
    int                   pool_size;
    int                   frame_len;
    int                   pick;
    int                   random_start;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Quads before any begin frame land in the reset batch, which is
    // an empty batch like any other.
    send_request(OP_PLAIN, 16'h1234);
    send_request(OP_TEXTURED, 16'h0000);
    send_request(OP_TEXTURED, 16'hFFFF);
    // Same id again must hit its slot instead of taking a new one.
    send_request(OP_TEXTURED, 16'h0000);
    // End frame flushes but keeps the batch, so the next quad joins it.
    send_request(OP_END, 16'hFFFF);
    send_request(OP_PLAIN, 16'h0000);
    // Begin frame empties everything; end frame on an empty batch says nothing.
    send_request(OP_BEGIN, 16'hFFFF);
    send_request(OP_END, 16'h0000);
    // Fill all fifteen bindable slots, then one more id forces a flush followed by
    // the new id taking slot 1 in a fresh batch.
    for (int k = 0; k < TEXTURE_SLOTS_DEF - 1; k++) begin
      send_request(OP_TEXTURED, 16'hA5A0 ^ k[IN_DATA_W-1:0]);
    end
    send_request(OP_TEXTURED, 16'h5A5A);
    send_request(OP_TEXTURED, 16'hA5A0);
    drain_results();

    // Random part, mostly whole frames over a small id pool so that slots are hit,
    // filled and flushed; about one in ten picks is a bare random request.
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(op_t'($urandom_range(0, 3)), IN_DATA_W'($urandom_range(0, 16'hFFFF)));
      end else begin
        pool_size = $urandom_range(1, 24);
        for (int k = 0; k < 24; k++) tex_pool[k] = random_id();
        if ($urandom_range(0, 7) != 0)
          send_request(OP_BEGIN, IN_DATA_W'($urandom_range(0, 16'hFFFF)));
        frame_len = $urandom_range(1, 60);
        for (int k = 0; k < frame_len; k++) begin
          pick = $urandom_range(0, 9);
          if (pick < 3)
            send_request(OP_PLAIN, IN_DATA_W'($urandom_range(0, 16'hFFFF)));
          else if (pick < 9)
            send_request(OP_TEXTURED, tex_pool[$urandom_range(0, pool_size - 1)]);
          else
            send_request(OP_END, IN_DATA_W'($urandom_range(0, 16'hFFFF)));
        end
        if ($urandom_range(0, 3) != 0)
          send_request(OP_END, IN_DATA_W'($urandom_range(0, 16'hFFFF)));
        if ($urandom_range(0, 5) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("Covered %0d requests: directed corners, then random frames with slot reuse,",
             items_sent);
    $display("table-full flushes and end-of-frame reports under stalls; %0d results checked.",
             results_checked);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/qbtsb_pkg.sv
rtl/core/qbtsb_cell.sv
rtl/core/quad_batch_texture_slot_binder.sv
dv/qbtsb_bind_checker.sv
dv/tb.sv
